// ===== design/ps2md_pkg.sv =====
// Shared types and constants for the PS/2 mouse device emulator.
// Depends on nothing; every other design file but the checker imports it.
package ps2md_pkg;

	// Item kinds on the input channel.
	localparam logic [1:0] KIND_MOVE = 2'd0;
	localparam logic [1:0] KIND_CMD  = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;

	// Host commands.
	localparam logic [7:0] CMD_RESET     = 8'hff;
	localparam logic [7:0] CMD_DEFAULTS  = 8'hf6;
	localparam logic [7:0] CMD_DISABLE   = 8'hf5;
	localparam logic [7:0] CMD_ENABLE    = 8'hf4;
	localparam logic [7:0] CMD_SET_RATE  = 8'hf3;
	localparam logic [7:0] CMD_GET_ID    = 8'hf2;
	localparam logic [7:0] CMD_READ_DATA = 8'heb;
	localparam logic [7:0] CMD_STATUS    = 8'he9;

	// Reply bytes and packet constants.
	localparam logic [7:0] BYTE_ACK       = 8'hfa;
	localparam logic [7:0] BYTE_BAT       = 8'haa;
	localparam logic [7:0] BYTE_BAT_SUBST = 8'hab;
	localparam logic [7:0] STATUS_STREAM  = 8'h20;
	localparam logic [7:0] STATUS_SECOND  = 8'h02;
	localparam logic [7:0] PKT_ALWAYS_ONE = 8'h08;
	localparam logic [7:0] PKT_X_SIGN     = 8'h10;
	localparam logic [7:0] PKT_Y_SIGN     = 8'h20;
	localparam logic [7:0] RATE_DEFAULT   = 8'd100;

	// Rate knock sequences that unlock the extended modes.
	localparam logic [23:0] SEQ_WHEEL = 24'hc86450;
	localparam logic [23:0] SEQ_FIVE  = 24'hc8c850;

	// Device identifiers.
	localparam logic [2:0] ID_STANDARD = 3'd0;
	localparam logic [2:0] ID_WHEEL    = 3'd3;
	localparam logic [2:0] ID_FIVE     = 3'd4;

	// Movement clamp limits.
	localparam logic signed [15:0] XY_MAX = 16'sd255;
	localparam logic signed [15:0] XY_MIN = -16'sd255;
	localparam logic signed [7:0]  WHL_MAX = 8'sd7;
	localparam logic signed [7:0]  WHL_MIN = -8'sd8;

	// One reply run: up to four bytes and the index of the final one.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
	} ps2md_job_t;

endpackage

// ===== design/ps2md_front.sv =====
// Front end: accepts items, keeps the mouse state and builds reply runs.
// Depends on ps2md_pkg; feeds ps2md_queue.
module ps2md_front import ps2md_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [1:0]        kind,
	input  logic [7:0]        buttons,
	input  logic signed [7:0] move_x,
	input  logic signed [7:0] move_y,
	input  logic signed [7:0] move_wheel,
	input  logic [7:0]        host_byte,
	input  logic [7:0]        prev_host_byte,
	input  logic              line_busy,
	output logic              push,
	output ps2md_job_t        job
);

	logic               streaming_on_q, moving_flag_q;
	logic [23:0]        rate_history_q;
	logic [2:0]         device_id_q;
	logic [7:0]         sample_rate_q, button_state_q;
	logic signed [15:0] acc_x_q, acc_y_q;
	logic signed [7:0]  acc_wheel_q;

	logic               streaming_d, moving_d;
	logic [23:0]        rate_history_d;
	logic [2:0]         device_id_d;
	logic [7:0]         sample_rate_d, button_state_d;
	logic signed [15:0] acc_x_d, acc_y_d;
	logic signed [7:0]  acc_wheel_d;

	logic [23:0]        hist_shift;
	logic [7:0]         clamp_x, clamp_y, neg_y, pkt_b1, pkt_b2, pkt_b3, pkt_b4;
	logic signed [7:0]  wheel_neg, wheel_clamp;
	logic signed [15:0] excess_x, excess_y;
	logic               all_zero, ext_mode;

	// Packet fields derived from the current accumulators.
	always_comb begin
		clamp_x = (acc_x_q < XY_MIN) ? 8'h01 : (acc_x_q > XY_MAX) ? 8'hff : acc_x_q[7:0];
		clamp_y = (acc_y_q < XY_MIN) ? 8'h01 : (acc_y_q > XY_MAX) ? 8'hff : acc_y_q[7:0];
		neg_y   = 8'h00 - clamp_y;
		pkt_b1  = PKT_ALWAYS_ONE | {5'b0, button_state_q[2:0]}
			| ((acc_x_q < 16'sd0) ? PKT_X_SIGN : 8'h00)
			| ((acc_y_q > 16'sd0) ? PKT_Y_SIGN : 8'h00);
		pkt_b2  = (clamp_x == BYTE_BAT) ? BYTE_BAT_SUBST : clamp_x;
		pkt_b3  = (neg_y == BYTE_BAT) ? BYTE_BAT_SUBST : neg_y;
		wheel_neg   = 8'sd0 - acc_wheel_q;
		wheel_clamp = (wheel_neg < WHL_MIN) ? WHL_MIN
			: (wheel_neg > WHL_MAX) ? WHL_MAX : wheel_neg;
		pkt_b4 = (device_id_q == ID_FIVE)
			? {2'b00, button_state_q[4:3], wheel_clamp[3:0]} : wheel_clamp;
		excess_x = (acc_x_q < XY_MIN) ? acc_x_q + XY_MAX
			: (acc_x_q > XY_MAX) ? acc_x_q - XY_MAX : 16'sd0;
		excess_y = (acc_y_q < XY_MIN) ? acc_y_q + XY_MAX
			: (acc_y_q > XY_MAX) ? acc_y_q - XY_MAX : 16'sd0;
		all_zero = (button_state_q == 8'h00) && (acc_x_q == 16'sd0)
			&& (acc_y_q == 16'sd0) && (acc_wheel_q == 8'sd0);
		ext_mode = (device_id_q == ID_WHEEL) || (device_id_q == ID_FIVE);
		hist_shift = {rate_history_q[15:0], host_byte};
	end

	// Classify the item, update the state and build its reply run.
	always_comb begin
		streaming_d    = streaming_on_q;
		moving_d       = moving_flag_q;
		rate_history_d = rate_history_q;
		device_id_d    = device_id_q;
		sample_rate_d  = sample_rate_q;
		button_state_d = button_state_q;
		acc_x_d        = acc_x_q;
		acc_y_d        = acc_y_q;
		acc_wheel_d    = acc_wheel_q;
		push           = 1'b0;
		job.bytes      = {4{BYTE_ACK}};
		job.last_idx   = 2'd0;
		unique case (kind)
			KIND_MOVE: begin
				button_state_d = buttons;
				acc_x_d        = acc_x_q + 16'(move_x);
				acc_y_d        = acc_y_q + 16'(move_y);
				acc_wheel_d    = acc_wheel_q + move_wheel;
			end
			KIND_CMD: begin
				push = 1'b1;
				// Most commands drop pending motion; status and read data keep it.
				if (prev_host_byte == CMD_SET_RATE || (host_byte != CMD_STATUS
					&& host_byte != CMD_READ_DATA)) begin
					moving_d       = 1'b0;
					button_state_d = 8'h00;
					acc_x_d        = 16'sd0;
					acc_y_d        = 16'sd0;
					acc_wheel_d    = 8'sd0;
				end
				if (prev_host_byte == CMD_SET_RATE) begin
					sample_rate_d  = host_byte;
					rate_history_d = hist_shift;
					if (device_id_q == ID_STANDARD && hist_shift == SEQ_WHEEL) begin
						device_id_d = ID_WHEEL;
					end else if (device_id_q == ID_WHEEL && hist_shift == SEQ_FIVE) begin
						device_id_d = ID_FIVE;
					end
				end else begin
					unique case (host_byte)
						CMD_RESET: begin
							device_id_d   = ID_STANDARD;
							sample_rate_d = RATE_DEFAULT;
							streaming_d   = 1'b0;
						end
						CMD_DEFAULTS: begin
							sample_rate_d = RATE_DEFAULT;
							streaming_d   = 1'b0;
						end
						CMD_DISABLE: streaming_d = 1'b0;
						CMD_ENABLE:  streaming_d = 1'b1;
						CMD_GET_ID: begin
							job.bytes[1] = {5'b0, device_id_q};
							job.last_idx = 2'd1;
						end
						CMD_READ_DATA: moving_d = 1'b1;
						CMD_STATUS: begin
							job.bytes[1] = streaming_on_q ? STATUS_STREAM : 8'h00;
							job.bytes[2] = STATUS_SECOND;
							job.bytes[3] = sample_rate_q;
							job.last_idx = 2'd3;
						end
						default: ;
					endcase
				end
			end
			KIND_TICK: begin
				if (streaming_on_q && !line_busy && (!all_zero || moving_flag_q)) begin
					push         = 1'b1;
					moving_d     = !all_zero;
					job.bytes    = {pkt_b4, pkt_b3, pkt_b2, pkt_b1};
					job.last_idx = ext_mode ? 2'd3 : 2'd2;
					acc_x_d      = excess_x;
					acc_y_d      = excess_y;
					acc_wheel_d  = 8'sd0;
				end
			end
			default: ;
		endcase
	end

	// Mouse state registers, updated once per accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			streaming_on_q <= 1'b0;
			moving_flag_q  <= 1'b0;
			rate_history_q <= 24'h0;
			device_id_q    <= ID_STANDARD;
			sample_rate_q  <= RATE_DEFAULT;
			button_state_q <= 8'h00;
			acc_x_q        <= 16'sd0;
			acc_y_q        <= 16'sd0;
			acc_wheel_q    <= 8'sd0;
		end else if (accept) begin
			streaming_on_q <= streaming_d;
			moving_flag_q  <= moving_d;
			rate_history_q <= rate_history_d;
			device_id_q    <= device_id_d;
			sample_rate_q  <= sample_rate_d;
			button_state_q <= button_state_d;
			acc_x_q        <= acc_x_d;
			acc_y_q        <= acc_y_d;
			acc_wheel_q    <= acc_wheel_d;
		end
	end

endmodule

// ===== design/ps2md_queue.sv =====
// Short queue of reply runs between the front end and the byte sender.
// Depends on ps2md_pkg for the run type.
module ps2md_queue import ps2md_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  ps2md_job_t push_job,
	input  logic       pop,
	output ps2md_job_t head,
	output logic       not_empty,
	output logic       full
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	ps2md_job_t       entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head      = entry_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_W'(DEPTH));

	// Entry storage, written at the tail.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/ps2md_back.sv =====
// Back end: sends the queued reply runs one byte per beat.
// Depends on ps2md_pkg; reads the head of ps2md_queue.
module ps2md_back import ps2md_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  ps2md_job_t head,
	input  logic       not_empty,
	output logic       pop,
	input  logic       out_stall,
	output logic       out_valid,
	output logic [7:0] out_byte,
	output logic       last
);

	logic       valid_q, last_q;
	logic [7:0] byte_q;
	logic [1:0] idx_q;
	logic       load, take, at_end;

	// The output register refills when it is empty or its beat is taken.
	assign load   = !valid_q || !out_stall;
	assign take   = load && not_empty;
	assign at_end = (idx_q == head.last_idx);
	assign pop    = take && at_end;

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign last      = last_q;

	// Output register payload.
	always_ff @(posedge clk) begin
		if (take) begin
			byte_q <= head.bytes[idx_q];
			last_q <= at_end;
		end
	end

	// Output valid and byte position within the head run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load) begin
			valid_q <= not_empty;
			if (take) begin
				idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

endmodule

// ===== design/ps2_mouse_device_emulator.sv =====
// Top level of the PS/2 mouse device emulator.
// Depends on ps2md_pkg, ps2md_front, ps2md_queue and ps2md_back.
//
//   Channel  Handshake             Payload
//   input    in_valid / in_stall   kind, buttons, move_x, move_y, move_wheel,
//                                  host_byte, prev_host_byte, line_busy
//   output   out_valid / out_stall out_byte, last
//
// An item is taken whenever the run queue has room; its state update is
// done in the cycle it is taken. Replies leave one byte per cycle while
// out_stall is low; a wheel-mode tick or a status command is four bytes from
// the single byte sender. in_stall rises only while QUEUE_DEPTH runs wait.
// Reset clears all mouse state and the queue at once; no clearing pass.
module ps2_mouse_device_emulator import ps2md_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        kind,
	input  logic [7:0]        buttons,
	input  logic signed [7:0] move_x,
	input  logic signed [7:0] move_y,
	input  logic signed [7:0] move_wheel,
	input  logic [7:0]        host_byte,
	input  logic [7:0]        prev_host_byte,
	input  logic              line_busy,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_byte,
	output logic              last
);

	ps2md_job_t push_job, head;
	logic       push, pop, not_empty, full, accept;

	// Items are held off only while the queue is full.
	assign in_stall = full;
	assign accept   = in_valid && !full;

	ps2md_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.kind          (kind),
		.buttons       (buttons),
		.move_x        (move_x),
		.move_y        (move_y),
		.move_wheel    (move_wheel),
		.host_byte     (host_byte),
		.prev_host_byte(prev_host_byte),
		.line_busy     (line_busy),
		.push          (push),
		.job           (push_job)
	);

	ps2md_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push && accept),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.not_empty(not_empty),
		.full     (full)
	);

	ps2md_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.not_empty(not_empty),
		.pop      (pop),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_byte (out_byte),
		.last     (last)
	);

endmodule

// ===== design/ps2md_checker.sv =====
// Port-level checks for the PS/2 mouse device emulator, bound to the top.
// Depends only on the top level's ports.
module ps2md_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       last
);

	// A stalled output beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last))
		else $error("output beat changed while stalled");

	// A run, once started, sends its remaining bytes without gaps.
	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("gap inside a reply run");

	// The input side is held off only while replies are waiting to go out.
	a_stall_backed: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no reply pending");

endmodule

bind ps2_mouse_device_emulator ps2md_checker u_ps2md_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_byte (out_byte),
	.last     (last)
);
